/* src/job_slot_dispatch_queue_top_assert.svh */
// ----------------------------------------------------------------------------
// Job slot dispatch queue assertion macros
// Concurrent check macros shared by the dispatch queue RTL.
// ----------------------------------------------------------------------------
`ifndef JOB_SLOT_DISPATCH_QUEUE_TOP_ASSERT_SVH
`define JOB_SLOT_DISPATCH_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define JSDQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define JSDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/jsdq_pkg.sv */
// ----------------------------------------------------------------------------
// Job slot dispatch queue package
// Sizes, request/status/phase codes and item types of the dispatch queue.
// ----------------------------------------------------------------------------
package jsdq_pkg;

   localparam int JOB_SLOTS   = 16;
   localparam int GROUP_COUNT = 16;
   localparam int QUEUE_DEPTH = 16;

   localparam int REQ_W    = 3;
   localparam int JOB_W    = 4;
   localparam int GROUP_W  = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
   localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);

   typedef logic [REQ_W-1:0]    req_code_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [1:0]          phase_type;
   typedef logic [JOB_W-1:0]    job_type;
   typedef logic [GROUP_W-1:0]  group_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [QPTR_W-1:0]   qptr_type;
   typedef logic [FILL_W-1:0]   fill_type;

   localparam req_code_type REQ_SUBMIT      = 3'd0;
   localparam req_code_type REQ_DISPATCH    = 3'd1;
   localparam req_code_type REQ_FINISH      = 3'd2;
   localparam req_code_type REQ_FREE        = 3'd3;
   localparam req_code_type REQ_QUERY_DONE  = 3'd4;
   localparam req_code_type REQ_QUERY_GROUP = 3'd5;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_FULL     = 2'd1;
   localparam status_type ST_EMPTY    = 2'd2;
   localparam status_type ST_BADSTATE = 2'd3;

   localparam phase_type PH_FREE = 2'd0;
   localparam phase_type PH_WAIT = 2'd1;
   localparam phase_type PH_WORK = 2'd2;
   localparam phase_type PH_DONE = 2'd3;

   localparam count_type COUNT_MAX = 5'd31;

   typedef struct packed {
      req_code_type req_type;
      job_type      job_id;
      group_type    group_id;
      logic         auto_release;
   } req_item_type;

   typedef struct packed {
      status_type status;
      job_type    slot_out;
      logic       is_complete;
      count_type  group_running;
      fill_type   queued_total;
   } rsp_item_type;

   // ready ring entry keeps the group next to the slot so dispatch needs no table lookup
   typedef struct packed {
      job_type   slot;
      group_type group;
   } ring_entry_type;

endpackage

/* src/jsdq_if.sv */
// ----------------------------------------------------------------------------
// Job slot dispatch queue channel interfaces
// Valid/ready request and response channels of the dispatch queue.
// ----------------------------------------------------------------------------
interface jsdq_req_if;
   logic                   valid;
   logic                   ready;
   jsdq_pkg::req_code_type req_type;
   jsdq_pkg::job_type      job_id;
   jsdq_pkg::group_type    group_id;
   logic                   auto_release;

   modport source (output valid, output req_type, output job_id, output group_id,
                   output auto_release, input ready);
   modport sink   (input valid, input req_type, input job_id, input group_id,
                   input auto_release, output ready);
endinterface

interface jsdq_rsp_if;
   logic                 valid;
   logic                 ready;
   jsdq_pkg::status_type status;
   jsdq_pkg::job_type    slot_out;
   logic                 is_complete;
   jsdq_pkg::count_type  group_running;
   jsdq_pkg::fill_type   queued_total;

   modport source (output valid, output status, output slot_out, output is_complete,
                   output group_running, output queued_total, input ready);
   modport sink   (input valid, input status, input slot_out, input is_complete,
                   input group_running, input queued_total, output ready);
endinterface

/* src/job_slot_dispatch_queue_top.sv */
// ----------------------------------------------------------------------------
// Job slot dispatch queue
// Task table with lowest-free slot allocation, per-group running counts and
// an in-order ready ring. Each request item (submit, dispatch, finish, free,
// query complete, query group) yields exactly one response item. Requests are
// captured in an input register, handled by one pass of logic over the slot
// table, group counters and ready ring, and the response lands in an output
// register: one item per cycle sustained while the response port is ready.
// The throughput is set by the read-modify-write of the group counter and
// slot phase table in one pass of logic. The input register keeps taking
// items while a response waits, until both stages are full. No clearing
// pass after reset: the phase table and group counters reset in flops.
// ----------------------------------------------------------------------------
`include "job_slot_dispatch_queue_top_assert.svh"

module job_slot_dispatch_queue_top (
   input logic       clock,
   input logic       reset,
   jsdq_req_if.sink  req_port,
   jsdq_rsp_if.source rsp_port
);
   import jsdq_pkg::*;

   // pipeline control
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;
   logic         advance, step, req_take;

   // state
   phase_type      phase_ff [JOB_SLOTS];
   phase_type      phase_in [JOB_SLOTS];
   group_type      slot_group_ff [JOB_SLOTS];
   logic           slot_auto_ff [JOB_SLOTS];
   count_type      count_ff [GROUP_COUNT];
   ring_entry_type ring_ff [QUEUE_DEPTH];
   qptr_type       rd_ptr_ff, rd_ptr_in;
   qptr_type       wr_ptr_ff, wr_ptr_in;
   fill_type       fill_ff, fill_in;

   // single-pass datapath
   logic           free_found;
   job_type        free_idx;
   ring_entry_type head;
   group_type      cnt_addr;
   count_type      cnt_rd, cnt_new;
   logic           cnt_we, slot_we, push, pop;
   logic [JOB_SLOTS-1:0] wait_vec;

   assign advance  = !rsp_valid_ff || rsp_port.ready;
   assign step     = in_valid_ff && advance;
   assign req_port.ready = !in_valid_ff || advance;
   assign req_take = req_port.valid && req_port.ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = JOB_SLOTS - 1; i >= 0; i--) begin
         if (phase_ff[i] == PH_FREE) begin
            free_found = 1'b1;
            free_idx   = JOB_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < JOB_SLOTS; i++) begin
         wait_vec[i] = (phase_ff[i] == PH_WAIT);
      end
   end

   assign head = ring_ff[rd_ptr_ff];

   // one counter read port; the request picks which group it touches
   always_comb begin
      unique case (in_item_ff.req_type)
         REQ_DISPATCH: begin
            cnt_addr = head.group;
         end
         REQ_FINISH: begin
            cnt_addr = slot_group_ff[in_item_ff.job_id];
         end
         default: begin
            cnt_addr = in_item_ff.group_id;
         end
      endcase
   end

   assign cnt_rd = count_ff[cnt_addr];

   always_comb begin
      phase_in = phase_ff;
      cnt_we   = 1'b0;
      cnt_new  = cnt_rd;
      slot_we  = 1'b0;
      push     = 1'b0;
      pop      = 1'b0;
      rsp_in   = '0;
      rsp_in.status = ST_OK;

      unique case (in_item_ff.req_type)
         REQ_SUBMIT: begin
            if (int'(in_item_ff.group_id) >= GROUP_COUNT) begin
               rsp_in.status = ST_BADSTATE;
            end else if (!free_found || fill_ff >= FILL_W'(QUEUE_DEPTH)) begin
               rsp_in.status = ST_FULL;
            end else begin
               phase_in[free_idx] = PH_WAIT;
               slot_we = 1'b1;
               push    = 1'b1;
               cnt_we  = 1'b1;
               cnt_new = (cnt_rd < COUNT_MAX) ? cnt_rd + 1'b1 : cnt_rd;
               rsp_in.slot_out      = free_idx;
               rsp_in.group_running = cnt_new;
            end
         end
         REQ_DISPATCH: begin
            if (fill_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               pop = 1'b1;
               phase_in[head.slot] = PH_WORK;
               rsp_in.slot_out      = head.slot;
               rsp_in.group_running = cnt_rd;
            end
         end
         REQ_FINISH: begin
            if (int'(in_item_ff.job_id) >= JOB_SLOTS ||
                phase_ff[in_item_ff.job_id] != PH_WORK) begin
               rsp_in.status = ST_BADSTATE;
               rsp_in.is_complete = (int'(in_item_ff.job_id) < JOB_SLOTS) &&
                                    (phase_ff[in_item_ff.job_id] == PH_DONE);
            end else begin
               cnt_we  = 1'b1;
               cnt_new = (cnt_rd != '0) ? cnt_rd - 1'b1 : cnt_rd;
               phase_in[in_item_ff.job_id] =
                  slot_auto_ff[in_item_ff.job_id] ? PH_FREE : PH_DONE;
               rsp_in.is_complete   = !slot_auto_ff[in_item_ff.job_id];
               rsp_in.group_running = cnt_new;
            end
         end
         REQ_FREE: begin
            if (int'(in_item_ff.job_id) >= JOB_SLOTS ||
                phase_ff[in_item_ff.job_id] != PH_DONE) begin
               rsp_in.status = ST_BADSTATE;
            end else begin
               phase_in[in_item_ff.job_id] = PH_FREE;
            end
         end
         REQ_QUERY_DONE: begin
            if (int'(in_item_ff.job_id) >= JOB_SLOTS) begin
               rsp_in.status = ST_BADSTATE;
            end else begin
               rsp_in.is_complete = (phase_ff[in_item_ff.job_id] == PH_DONE);
            end
         end
         REQ_QUERY_GROUP: begin
            if (int'(in_item_ff.group_id) >= GROUP_COUNT) begin
               rsp_in.status = ST_BADSTATE;
            end else begin
               rsp_in.group_running = cnt_rd;
            end
         end
         default: begin
            // unused codes: no operation
         end
      endcase

      // push and pop never happen together
      if (push) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop) begin
         fill_in = fill_ff - 1'b1;
      end else begin
         fill_in = fill_ff;
      end
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      rsp_in.queued_total = fill_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         for (int i = 0; i < JOB_SLOTS; i++) begin
            phase_ff[i] <= PH_FREE;
         end
         for (int g = 0; g < GROUP_COUNT; g++) begin
            count_ff[g] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            phase_ff  <= phase_in;
            rd_ptr_ff <= rd_ptr_in;
            wr_ptr_ff <= wr_ptr_in;
            fill_ff   <= fill_in;
            if (cnt_we) begin
               count_ff[cnt_addr] <= cnt_new;
            end
         end
      end
   end

   // payload and write-before-read tables
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.req_type     <= req_port.req_type;
         in_item_ff.job_id       <= req_port.job_id;
         in_item_ff.group_id     <= req_port.group_id;
         in_item_ff.auto_release <= req_port.auto_release;
      end
      if (step) begin
         rsp_ff <= rsp_in;
         if (slot_we) begin
            slot_group_ff[free_idx] <= in_item_ff.group_id;
            slot_auto_ff[free_idx]  <= in_item_ff.auto_release;
         end
         if (push) begin
            ring_ff[wr_ptr_ff] <= '{slot: free_idx, group: in_item_ff.group_id};
         end
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.status        = rsp_ff.status;
   assign rsp_port.slot_out      = rsp_ff.slot_out;
   assign rsp_port.is_complete   = rsp_ff.is_complete;
   assign rsp_port.group_running = rsp_ff.group_running;
   assign rsp_port.queued_total  = rsp_ff.queued_total;

   `JSDQ_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(QUEUE_DEPTH), "ready ring fill above depth")
   `JSDQ_ASSERT_IMPLY(a_fill_matches_waiting, clock, reset, 1'b1, $countones(wait_vec) == int'(fill_ff), "ready ring fill differs from waiting slot count")
   `JSDQ_ASSERT_NEXT(a_dispatch_working, clock, reset, step && pop, phase_ff[$past(head.slot)] == PH_WORK, "dispatched slot not working")
   `JSDQ_ASSERT_NEXT(a_step_gives_rsp, clock, reset, step, rsp_valid_ff, "handled item produced no response")

endmodule
